[design/ray_plane_checker_shade_unit_macros.svh]
// Assertion macros shared by the ray plane checker shade unit.
// Every macro samples on clk_i; the including module must declare clk_i and rst_ni.
`ifndef RAY_PLANE_CHECKER_SHADE_UNIT_MACROS_SVH
`define RAY_PLANE_CHECKER_SHADE_UNIT_MACROS_SVH

// Checked only while the block is out of reset.
`define RPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define RPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/rpc_pkg.sv]
// Shared types and constants of the ray plane checker shade unit.
// No dependencies; every module of the block and the testbench imports it.
package rpc_pkg;

  // Fixed-point format of the ray words.
  localparam int FRAC_BITS = 11;
  localparam int FACTOR    = 1 << FRAC_BITS;
  localparam int FRAC_MASK = FACTOR - 1;

  // Input fields are 32 bits wide on the stream.
  localparam int IN_FIELD_W = 32;

  // A square is four units wide; the board repeats every two squares.
  localparam int SQUARE_SPAN = 4 * FACTOR;
  localparam int CELL_LSB    = FRAC_BITS + 2;  // log2 of SQUARE_SPAN
  localparam int CELL_BITS   = CELL_LSB + 1;   // log2 of 2 * SQUARE_SPAN

  localparam int COLOR_W = 8;

  localparam logic [COLOR_W-1:0] SKY_RED     = 8'd0;
  localparam logic [COLOR_W-1:0] SKY_GREEN   = 8'd127;
  localparam logic [COLOR_W-1:0] SKY_BLUE    = 8'd127;
  localparam logic [COLOR_W-1:0] LIGHT_LEVEL = 8'd255;
  localparam logic [COLOR_W-1:0] DARK_LEVEL  = 8'd0;

  typedef enum logic [1:0] {
    REGION_SKY   = 2'd0,
    REGION_LIGHT = 2'd1,
    REGION_DARK  = 2'd2
  } region_e;

  typedef struct packed {
    region_e             region;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
  } rpc_result_t;

endpackage

[design/rpc_divider.sv]
// Pipelined restoring divider that yields the ray distance to the ground plane.
// Depends on rpc_pkg. One quotient bit per stage, side data travels with each item.
module rpc_divider #(
  parameter int WORD_WIDTH = 32,
  parameter int SIDE_WIDTH = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [WORD_WIDTH-1:0] oy_i,
  input  logic [WORD_WIDTH-1:0] dy_i,
  input  logic [SIDE_WIDTH-1:0] side_i,
  output logic                  valid_o,
  output logic [WORD_WIDTH-1:0] dist_o,
  output logic [SIDE_WIDTH-1:0] side_o
);
  import rpc_pkg::*;

  localparam int W = WORD_WIDTH;
  localparam logic [W-1:0] WordMin    = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] WordNegMax = {1'b1, {(W-2){1'b0}}, 1'b1};

  // Stage 0 holds the operand magnitudes, stage s+1 the state after quotient bit s.
  logic [W-1:0]          rem_q   [0:W];
  logic [W-1:0]          num_q   [0:W];
  logic [W-1:0]          den_q   [0:W];
  logic                  neg_q   [0:W];
  logic                  zero_q  [0:W];
  logic                  oyneg_q [0:W];
  logic [SIDE_WIDTH-1:0] side_q  [0:W];
  logic [W:0]            valid_q;

  logic [W-1:0] rem_d [0:W-1];
  logic [W-1:0] num_d [0:W-1];
  logic [W-1:0] trial [0:W-1];
  logic         ge    [0:W-1];

  logic [W-1:0] dividend;
  logic [W-1:0] dist_d;
  logic [W-1:0] dist_q;
  logic [SIDE_WIDTH-1:0] post_side_q;
  logic post_valid_q;

  assign dividend = {oy_i[W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};

  always_comb begin
    for (int s = 0; s < W; s++) begin
      trial[s] = {rem_q[s][W-2:0], num_q[s][W-1]};
      ge[s]    = (trial[s] >= den_q[s]);
      rem_d[s] = ge[s] ? (trial[s] - den_q[s]) : trial[s];
      num_d[s] = {num_q[s][W-2:0], ge[s]};
    end
  end

  // The distance is the negated quotient, so a negative quotient's magnitude passes unchanged.
  always_comb begin
    if (zero_q[W]) begin
      dist_d = oyneg_q[W] ? WordMin : WordNegMax;
    end else if (neg_q[W]) begin
      dist_d = num_q[W];
    end else begin
      dist_d = -num_q[W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      post_valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q      <= {valid_q[W-1:0], valid_i};
      post_valid_q <= valid_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]   <= '0;
      num_q[0]   <= dividend[W-1] ? -dividend : dividend;
      den_q[0]   <= dy_i[W-1] ? -dy_i : dy_i;
      neg_q[0]   <= dividend[W-1] ^ dy_i[W-1];
      zero_q[0]  <= (dy_i == '0);
      oyneg_q[0] <= oy_i[W-1];
      side_q[0]  <= side_i;
      for (int s = 0; s < W; s++) begin
        rem_q[s+1]   <= rem_d[s];
        num_q[s+1]   <= num_d[s];
        den_q[s+1]   <= den_q[s];
        neg_q[s+1]   <= neg_q[s];
        zero_q[s+1]  <= zero_q[s];
        oyneg_q[s+1] <= oyneg_q[s];
        side_q[s+1]  <= side_q[s];
      end
      dist_q      <= dist_d;
      post_side_q <= side_q[W];
    end
  end

  assign valid_o = post_valid_q;
  assign dist_o  = dist_q;
  assign side_o  = post_side_q;

endmodule

[design/rpc_hit.sv]
// Hit point stages: sky test, step count and the wrapped products origin + dir * step.
// Depends on rpc_pkg. Products are split into half-word partial products.
module rpc_hit #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [WORD_WIDTH-1:0]   dist_i,
  input  logic [4*WORD_WIDTH-1:0] side_i,  // origin_x, origin_z, dir_x, dir_z from bit 0
  output logic                    valid_o,
  output logic                    sky_o,
  output logic [WORD_WIDTH-1:0]   hx_o,
  output logic [WORD_WIDTH-1:0]   hz_o
);
  import rpc_pkg::*;

  localparam int W = WORD_WIDTH;
  localparam int H = (W + 1) / 2;
  localparam int L = W - H;
  localparam logic signed [W-1:0] FactorW = W'(FACTOR);
  localparam logic signed [W-1:0] BiasW   = W'(FRAC_MASK);

  // Step stage.
  logic                 p_valid_q, p_sky_q;
  logic signed [W-1:0]  p_step_q;
  logic [W-1:0]         p_ox_q, p_oz_q, p_dx_q, p_dz_q;
  logic signed [W-1:0]  dist_s, biased;

  // Partial product stage.
  logic                 m_valid_q, m_sky_q;
  logic [W-1:0]         m_ox_q, m_oz_q;
  logic [2*H-1:0]       m_llx_q, m_llz_q;
  logic [L-1:0]         m_hlx_q, m_lhx_q, m_hlz_q, m_lhz_q;
  logic [H-1:0]         st_lo;
  logic [L-1:0]         st_hi;

  // Sum stage.
  logic                 s_valid_q, s_sky_q;
  logic [W-1:0]         s_hx_q, s_hz_q;

  assign dist_s = dist_i;
  // Truncating division by one unit: bias negative values before the arithmetic shift.
  assign biased = dist_s + (dist_s[W-1] ? BiasW : '0);
  assign st_lo  = p_step_q[H-1:0];
  assign st_hi  = p_step_q[W-1:H];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else if (en_i) begin
      p_valid_q <= valid_i;
      m_valid_q <= p_valid_q;
      s_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_sky_q  <= (dist_s > FactorW);
      p_step_q <= biased >>> FRAC_BITS;
      p_ox_q   <= side_i[0*W +: W];
      p_oz_q   <= side_i[1*W +: W];
      p_dx_q   <= side_i[2*W +: W];
      p_dz_q   <= side_i[3*W +: W];

      m_sky_q <= p_sky_q;
      m_ox_q  <= p_ox_q;
      m_oz_q  <= p_oz_q;
      m_llx_q <= (2*H)'(p_dx_q[H-1:0]) * (2*H)'(st_lo);
      m_hlx_q <= L'(p_dx_q[W-1:H] * st_lo);
      m_lhx_q <= L'(p_dx_q[H-1:0] * st_hi);
      m_llz_q <= (2*H)'(p_dz_q[H-1:0]) * (2*H)'(st_lo);
      m_hlz_q <= L'(p_dz_q[W-1:H] * st_lo);
      m_lhz_q <= L'(p_dz_q[H-1:0] * st_hi);

      s_sky_q <= m_sky_q;
      s_hx_q  <= m_ox_q + W'(m_llx_q) + {L'(m_hlx_q + m_lhx_q), {H{1'b0}}};
      s_hz_q  <= m_oz_q + W'(m_llz_q) + {L'(m_hlz_q + m_lhz_q), {H{1'b0}}};
    end
  end

  assign valid_o = s_valid_q;
  assign sky_o   = s_sky_q;
  assign hx_o    = s_hx_q;
  assign hz_o    = s_hz_q;

endmodule

[design/rpc_shade.sv]
// Checkerboard shading of a hit point, or the sky color for a far ray.
// Depends on rpc_pkg for the region codes and color levels.
module rpc_shade #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                      sky_i,
  input  logic [WORD_WIDTH-1:0]     hx_i,
  input  logic [WORD_WIDTH-1:0]     hz_i,
  output rpc_pkg::rpc_result_t      result_o
);
  import rpc_pkg::*;

  localparam int W    = WORD_WIDTH;
  localparam int ExtW = W + CELL_BITS;

  // Square index along one axis: |h / SQUARE_SPAN| taken modulo two squares.
  function automatic logic cell_high(input logic [W-1:0] h);
    logic [W-1:0]         m;
    logic [W-1:0]         mag;
    logic [ExtW-1:0]      ext;
    logic [CELL_BITS-1:0] cell_idx;
    m        = {h[W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    mag      = m[W-1] ? -m : m;
    ext      = ExtW'(mag);
    cell_idx = ext[CELL_LSB +: CELL_BITS];
    return cell_idx > CELL_BITS'(SQUARE_SPAN);
  endfunction

  always_comb begin
    if (sky_i) begin
      result_o = '{region: REGION_SKY, red: SKY_RED, green: SKY_GREEN, blue: SKY_BLUE};
    end else if (cell_high(hx_i) != cell_high(hz_i)) begin
      result_o = '{region: REGION_LIGHT, red: LIGHT_LEVEL, green: LIGHT_LEVEL,
                   blue: LIGHT_LEVEL};
    end else begin
      result_o = '{region: REGION_DARK, red: DARK_LEVEL, green: DARK_LEVEL,
                   blue: DARK_LEVEL};
    end
  end

endmodule

[design/ray_plane_checker_shade_unit.sv]
// Ray against ground plane y = 0 with checkerboard shading; uses rpc_pkg and the macros header.
// Throughput: one item per cycle while the skid entry is empty, since a full
// skid entry holds the pipeline; the WORD_WIDTH stages of the divider set the depth.
// A two-entry output register and skid stage let one more item enter while a result waits.
// Reset (rst_ni low, asynchronous) empties every stage; outside reset no item is lost or repeated.
`include "ray_plane_checker_shade_unit_macros.svh"

module ray_plane_checker_shade_unit #(
  parameter int WORD_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input rays.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata from bit 0: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
  input  logic [191:0] s_axis_tdata_i,
  // Output pixels.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata from bit 0: red, green, blue (8 bits each)
  output logic [23:0]  m_axis_tdata_o,
  // tuser: region (2 bits)
  output logic [1:0]   m_axis_tuser_o
);
  import rpc_pkg::*;

  localparam int W = WORD_WIDTH;

  // Input fields, sign-extended or wrapped to the working word.
  logic signed [IN_FIELD_W-1:0] in_ox, in_oy, in_oz, in_dx, in_dy, in_dz;
  logic [W-1:0]   ox, oy, oz, dx, dy, dz;
  logic [4*W-1:0] side;

  // Pipeline control. The whole pipeline moves whenever the skid entry is free,
  // so ready comes straight from a register.
  logic en;
  logic accept;

  logic           div_valid;
  logic [W-1:0]   div_dist;
  logic [4*W-1:0] div_side;

  logic         hit_valid, hit_sky;
  logic [W-1:0] hit_hx, hit_hz;

  rpc_result_t shade_res;

  // Output register and skid entry.
  logic        out_valid_q, out_valid_d;
  rpc_result_t out_q, out_d;
  logic        skid_valid_q, skid_valid_d;
  rpc_result_t skid_q, skid_d;
  logic        exit_v, pop;

  assign in_ox = s_axis_tdata_i[0*IN_FIELD_W +: IN_FIELD_W];
  assign in_oy = s_axis_tdata_i[1*IN_FIELD_W +: IN_FIELD_W];
  assign in_oz = s_axis_tdata_i[2*IN_FIELD_W +: IN_FIELD_W];
  assign in_dx = s_axis_tdata_i[3*IN_FIELD_W +: IN_FIELD_W];
  assign in_dy = s_axis_tdata_i[4*IN_FIELD_W +: IN_FIELD_W];
  assign in_dz = s_axis_tdata_i[5*IN_FIELD_W +: IN_FIELD_W];

  assign ox = W'(in_ox);
  assign oy = W'(in_oy);
  assign oz = W'(in_oz);
  assign dx = W'(in_dx);
  assign dy = W'(in_dy);
  assign dz = W'(in_dz);

  // The divider carries the remaining ray fields along with each item.
  assign side = {dz, dx, oz, ox};

  assign en              = !skid_valid_q;
  assign s_axis_tready_o = en;
  assign accept          = s_axis_tvalid_i && en;

  // Distance to the plane: the negated fixed-point quotient of origin y over direction y.
  rpc_divider #(
    .WORD_WIDTH (W),
    .SIDE_WIDTH (4 * W)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (accept),
    .oy_i    (oy),
    .dy_i    (dy),
    .side_i  (side),
    .valid_o (div_valid),
    .dist_o  (div_dist),
    .side_o  (div_side)
  );

  // Sky test and hit point in x and z.
  rpc_hit #(
    .WORD_WIDTH (W)
  ) u_hit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .dist_i  (div_dist),
    .side_i  (div_side),
    .valid_o (hit_valid),
    .sky_o   (hit_sky),
    .hx_o    (hit_hx),
    .hz_o    (hit_hz)
  );

  // Color of the pixel; registered by the output stage below.
  rpc_shade #(
    .WORD_WIDTH (W)
  ) u_shade (
    .sky_i    (hit_sky),
    .hx_i     (hit_hx),
    .hz_i     (hit_hz),
    .result_o (shade_res)
  );

  // An item leaves the pipeline whenever the pipeline moves and its last stage is full.
  // It goes to the output register if that is free or being emptied, otherwise to
  // the skid entry, which then holds the pipeline until the output drains it.
  assign exit_v = en && hit_valid;
  assign pop    = out_valid_q && m_axis_tready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_d = exit_v;
      out_d       = shade_res;
    end else if (exit_v) begin
      skid_valid_d = 1'b1;
      skid_d       = shade_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.blue, out_q.green, out_q.red};
  assign m_axis_tuser_o  = out_q.region;

  // The skid entry only ever holds an item behind a waiting output item.
  `RPC_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid full with output empty")
  // The skid entry fills only when the output was stalled in the cycle before.
  `RPC_ASSERT(a_skid_fill_on_stall,
              $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready_i),
              "skid filled without an output stall")
  // A cycle spent in reset leaves both output entries empty.
  `RPC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (!out_valid_q && !skid_valid_q),
                     "output entries not empty after reset")

endmodule

[sim/tb_top.sv]
// Self-checking testbench of ray_plane_checker_shade_unit: ray items in, pixel items out.
// Depends on rpc_pkg for the pixel struct, region codes and color levels.
module tb_top;
  import rpc_pkg::*;

  // One ray as it travels on the input stream; origin_x sits in the lowest bits.
  typedef struct packed {
    int dz;
    int dy;
    int dx;
    int oz;
    int oy;
    int ox;
  } ray_t;

  localparam int WORD_MAX = 32'sh7fff_ffff;
  localparam int WORD_MIN = 32'sh8000_0000;

  localparam rpc_result_t SKY_PIX   = '{REGION_SKY, SKY_RED, SKY_GREEN, SKY_BLUE};
  localparam rpc_result_t LIGHT_PIX = '{REGION_LIGHT, LIGHT_LEVEL, LIGHT_LEVEL, LIGHT_LEVEL};
  localparam rpc_result_t DARK_PIX  = '{REGION_DARK, DARK_LEVEL, DARK_LEVEL, DARK_LEVEL};

  // The block holds about 40 items, so the hold-off below fills it and
  // then keeps the input stalled.
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RAYS_PER_PHASE = 167;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [191:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [23:0]  m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  ray_plane_checker_shade_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Pixels still owed by the block, oldest first.
  rpc_result_t pixel_queue[$];
  int          errors = 0;
  int          stall_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req = 1'b0;

  // ---------------------------------------------------------------------
  // Pixel predictor. All words are 32-bit ints, so sums, products and
  // negations wrap exactly as the hardware words do.
  // ---------------------------------------------------------------------

  // Division that truncates toward zero and saturates on a zero divisor.
  // The smallest word over minus one wraps back to the smallest word.
  function automatic int trunc_div(int a, int b);
    longint ma, mb, q;
    if (b == 0) return (a < 0) ? WORD_MIN : WORD_MAX;
    ma = (a < 0) ? -longint'(a) : longint'(a);
    mb = (b < 0) ? -longint'(b) : longint'(b);
    q  = ma / mb;
    if ((a < 0) != (b < 0)) q = -q;
    return int'(q);
  endfunction

  // Fixed-point quotient; the saturation on a zero divisor follows the
  // sign of the unscaled dividend.
  function automatic int fix_div(int a, int b);
    if (b == 0) return (a < 0) ? WORD_MIN : WORD_MAX;
    return trunc_div(a * FACTOR, b);
  endfunction

  // True when the hit coordinate lies in the upper square of its period.
  function automatic bit upper_cell(int h);
    int     q;
    longint mq;
    q  = fix_div(h, SQUARE_SPAN);
    mq = (q < 0) ? -longint'(q) : longint'(q);
    return (mq % (2 * longint'(SQUARE_SPAN))) > longint'(SQUARE_SPAN);
  endfunction

  function automatic rpc_result_t shade_ray(ray_t r);
    int travel, steps, hx, hz;
    travel = -fix_div(r.oy, r.dy);
    if (travel > FACTOR) return SKY_PIX;
    steps = trunc_div(travel, FACTOR);
    hx = r.ox + r.dx * steps;
    hz = r.oz + r.dz * steps;
    return (upper_cell(hx) != upper_cell(hz)) ? LIGHT_PIX : DARK_PIX;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------

  function automatic int spread(int unsigned span);
    return int'($urandom_range(0, 2 * span)) - int'(span);
  endfunction

  // Mostly plausible camera rays with random content, so that sky, light
  // and dark all come up often; a quarter are raw words that toggle every bit.
  function automatic ray_t random_ray();
    ray_t r;
    if ($urandom_range(0, 3) == 0) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      r.ox = spread(1 << 20);
      r.oz = spread(1 << 20);
      r.oy = spread(1 << 16);
      r.dx = spread(1 << 16);
      r.dy = spread(1 << 16);
      r.dz = spread(1 << 16);
      if ($urandom_range(0, 15) == 0) r.dy = 0;
    end
    return r;
  endfunction

  // Offers one ray after a random gap, waits until it is taken, then
  // records the pixel it must produce. A fixed row carries its own pixel.
  task automatic send_ray(ray_t r, bit fixed, rpc_result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= r;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pixel_queue.push_back(fixed ? want : shade_ray(r));
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Directed table. Rows with a fixed pixel are ones whose answer is plain:
  // sky just past one unit, the one-unit boundary, square edges, zero divisors.
  // ---------------------------------------------------------------------
  typedef struct {
    ray_t        ray;
    bit          fixed;
    rpc_result_t want;
  } ray_row_t;

  ray_row_t plan[$];

  task automatic add_row(int ox, int oy, int oz, int dx, int dy, int dz,
                         bit fixed, rpc_result_t want);
    ray_row_t row;
    row.ray   = '{dz: dz, dy: dy, dx: dx, oz: oz, oy: oy, ox: ox};
    row.fixed = fixed;
    row.want  = want;
    plan.push_back(row);
  endtask

  task automatic build_plan();
    // Distance of two units, then just over one unit: both sky.
    add_row(0, 2048, 0, 0, -1024, 0, 1'b1, SKY_PIX);
    add_row(0, 2049, 0, 0, -2048, 0, 1'b1, SKY_PIX);
    // Exactly one unit still hits the board, and so does minus one unit.
    add_row(0, 2048, 0, 0, -2048, 0, 1'b1, DARK_PIX);
    add_row(0, 2048, 0, 0, 2048, 0, 1'b1, DARK_PIX);
    // One coordinate in the upper square gives light, both give dark.
    add_row(40000, 2048, 0, 0, 2048, 0, 1'b1, LIGHT_PIX);
    add_row(0, 2048, -40000, 0, 2048, 0, 1'b1, LIGHT_PIX);
    add_row(40000, 2048, 40000, 0, 2048, 0, 1'b1, DARK_PIX);
    // A square index equal to the square span is not above it; one more is.
    add_row(32768, 2048, 0, 0, 2048, 0, 1'b1, DARK_PIX);
    add_row(32772, 2048, 0, 0, 2048, 0, 1'b1, LIGHT_PIX);
    // Zero divisor with a zero and with a negative dividend; the second
    // negates the smallest word.
    add_row(0, 0, 0, 0, 0, 0, 1'b1, DARK_PIX);
    add_row(0, -5, 0, 0, 0, 0, 1'b1, DARK_PIX);
    // The scaled origin is the smallest word and is divided by minus one.
    add_row(0, -1048576, 0, 0, -1, 0, 1'b1, DARK_PIX);
    // Extremes and mixed corners, left to the predictor.
    add_row(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0, DARK_PIX);
    add_row(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b0, DARK_PIX);
    add_row(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, 1'b0, DARK_PIX);
    add_row(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, 1'b0, DARK_PIX);
    add_row(-1, -1, -1, -1, -1, -1, 1'b0, DARK_PIX);
    add_row(12345, 100, -777, 3000, 0, -5000, 1'b0, DARK_PIX);
    add_row(-40000, -9, 40000, WORD_MAX, 0, WORD_MIN, 1'b0, DARK_PIX);
    add_row(-40000, 4096, 7, 1000, 4096, -1000, 1'b0, DARK_PIX);
    add_row(5, -3000, -5, 20000, 6000, -20000, 1'b0, DARK_PIX);
    add_row(WORD_MIN, 1, WORD_MAX, 1, -1, -1, 1'b0, DARK_PIX);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold-off on request.
  // ---------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output checker and stall counter. Both handshakes are sampled at the
  // clock edge, before any of this edge's assignments take effect.
  // ---------------------------------------------------------------------
  rpc_result_t want_pix;
  bit          moved;

  always @(posedge clk_i) begin
    moved = s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      moved = 1'b1;
      if (pixel_queue.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, got region %0d rgb %h",
                 $time, m_axis_tuser_o, m_axis_tdata_o);
        errors++;
      end else begin
        want_pix = pixel_queue.pop_front();
        check_field("region", int'(want_pix.region), int'(m_axis_tuser_o));
        check_field("red", int'(want_pix.red), int'(m_axis_tdata_o[7:0]));
        check_field("green", int'(want_pix.green), int'(m_axis_tdata_o[15:8]));
        check_field("blue", int'(want_pix.blue), int'(m_axis_tdata_o[23:16]));
      end
    end
    stall_cycles <= moved ? 0 : stall_cycles + 1;
  end

  // Watchdog: too long without any item moving on either side.
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("ray_plane_checker_shade_unit regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence: reset, directed table, then three random phases with
  // different idling, the last one with the long receiver hold-off.
  // ---------------------------------------------------------------------
  initial begin
    build_plan();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 15;
    recv_idle_pct = 58;
    foreach (plan[i]) send_ray(plan[i].ray, plan[i].fixed, plan[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 58;
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 15;
        end
        default: begin
          // No idling at all, but the receiver first sits out a long stretch
          // while rays keep coming, so the block fills and stalls its input.
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req = 1'b1;
        end
      endcase
      repeat (RAYS_PER_PHASE) send_ray(random_ray(), 1'b0, DARK_PIX);
    end
    s_axis_tvalid_i <= 1'b0;

    while (pixel_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pixel_queue.size() != 0) begin
      $display("%0t: pixels missing, expected 0 pending, got %0d", $time, pixel_queue.size());
      errors++;
    end
    if (errors == 0) begin
      $display("ray_plane_checker_shade_unit regression: pass");
    end else begin
      $display("ray_plane_checker_shade_unit regression: fail");
    end
    $finish;
  end

endmodule
